// ----- hw/rtl/esbb_pkg.sv -----
// shared types, constants and helpers for the eye-space bounding billboard
`timescale 1ns / 1ps
package esbb_pkg;

  localparam int MAX_VERTICES_DEF = 65536;
  localparam int CoordW = 32;
  localparam int RowW = 64;
  localparam int EntryW = 16;
  localparam int SumW = 48;
  localparam int AccW = 50;
  localparam int FracDrop = 8;
  localparam int CfgIdxW = 3;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] REG_VIEW0 = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_VIEW1 = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_VIEW2 = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_INV0 = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_INV1 = 3'd4;
  localparam logic [CfgIdxW-1:0] REG_INV2 = 3'd5;

  localparam logic [RowW-1:0] ROW0_RST = 64'd256;
  localparam logic [RowW-1:0] ROW1_RST = 64'd256 << 16;
  localparam logic [RowW-1:0] ROW2_RST = 64'd256 << 32;

  typedef enum logic [2:0] {
    S_IDLE, S_XF, S_UPD, S_DINIT, S_DIV, S_DFIN, S_IXF, S_OUT
  } state_t;

  typedef struct packed {
    logic       load_in;
    logic       mac;
    logic       sel_inv;
    logic [1:0] row;
    logic [1:0] term;
    logic       load_corner;
    logic [2:0] corner;
    logic       update;
    logic       div_init;
    logic       div_step;
    logic       div_fin;
    logic       clear;
  } cmd_t;

  typedef struct packed {
    logic last;
  } status_t;

  // corner order: top-right, top-left, bottom-left, top-right, bottom-left, bottom-right
  function automatic logic corner_right(input logic [2:0] k);
    return (k == 3'd0) || (k == 3'd3) || (k == 3'd5);
  endfunction

  function automatic logic corner_bottom(input logic [2:0] k);
    return (k == 3'd2) || (k == 3'd4) || (k == 3'd5);
  endfunction

endpackage

// ----- hw/rtl/esbb_ctrl.sv -----
// controller state machine sequencing transform, divide and quad output
`timescale 1ns / 1ps
module esbb_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_stall,
  output logic             out_valid,
  input  logic             out_stall,
  input  esbb_pkg::status_t status,
  output esbb_pkg::cmd_t   cmd
);

  localparam int DivCntW = $clog2(esbb_pkg::SumW);

  esbb_pkg::state_t state, state_next;
  logic [1:0] row;
  logic [1:0] term;
  logic [2:0] corner;
  logic [DivCntW-1:0] div_cnt;
  logic mac_end;
  logic div_end;

  assign mac_end = (row == 2'd2) && (term == 2'd3);
  assign div_end = div_cnt == DivCntW'(esbb_pkg::SumW - 1);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= esbb_pkg::S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    unique case (state)
      esbb_pkg::S_IDLE: if (in_valid) state_next = esbb_pkg::S_XF;
      esbb_pkg::S_XF:   if (mac_end) state_next = esbb_pkg::S_UPD;
      esbb_pkg::S_UPD:  state_next = status.last ? esbb_pkg::S_DINIT : esbb_pkg::S_IDLE;
      esbb_pkg::S_DINIT: state_next = esbb_pkg::S_DIV;
      esbb_pkg::S_DIV:  if (div_end) state_next = esbb_pkg::S_DFIN;
      esbb_pkg::S_DFIN: state_next = esbb_pkg::S_IXF;
      esbb_pkg::S_IXF:  if (mac_end) state_next = esbb_pkg::S_OUT;
      esbb_pkg::S_OUT: begin
        if (!out_stall) begin
          state_next = (corner == 3'd5) ? esbb_pkg::S_IDLE : esbb_pkg::S_IXF;
        end
      end
      default: state_next = esbb_pkg::S_IDLE;
    endcase
  end

  // sequence counters
  always_ff @(posedge clk) begin
    if (rst) begin
      row <= 2'd0;
      term <= 2'd0;
      corner <= 3'd0;
      div_cnt <= '0;
    end else begin
      if (state == esbb_pkg::S_XF || state == esbb_pkg::S_IXF) begin
        if (term == 2'd3) begin
          term <= 2'd0;
          row <= mac_end ? 2'd0 : row + 2'd1;
        end else begin
          term <= term + 2'd1;
        end
      end
      if (state == esbb_pkg::S_DINIT) div_cnt <= '0;
      else if (state == esbb_pkg::S_DIV) div_cnt <= div_cnt + DivCntW'(1);
      if (state == esbb_pkg::S_DFIN) corner <= 3'd0;
      else if (state == esbb_pkg::S_OUT && !out_stall) begin
        corner <= (corner == 3'd5) ? 3'd0 : corner + 3'd1;
      end
    end
  end

  always_comb begin
    in_stall = state != esbb_pkg::S_IDLE;
    out_valid = state == esbb_pkg::S_OUT;
    cmd = '0;
    cmd.row = row;
    cmd.term = term;
    cmd.corner = corner;
    unique case (state)
      esbb_pkg::S_IDLE: cmd.load_in = in_valid;
      esbb_pkg::S_XF:   cmd.mac = 1'b1;
      esbb_pkg::S_UPD:  cmd.update = 1'b1;
      esbb_pkg::S_DINIT: cmd.div_init = 1'b1;
      esbb_pkg::S_DIV:  cmd.div_step = 1'b1;
      esbb_pkg::S_DFIN: begin
        cmd.div_fin = 1'b1;
        cmd.load_corner = 1'b1;
      end
      esbb_pkg::S_IXF: begin
        cmd.mac = 1'b1;
        cmd.sel_inv = 1'b1;
      end
      esbb_pkg::S_OUT: begin
        if (!out_stall) begin
          cmd.load_corner = corner != 3'd5;
          cmd.clear = corner == 3'd5;
        end
      end
      default: cmd = '0;
    endcase
    // next corner number during the load after an output transaction
    if (state == esbb_pkg::S_OUT) cmd.corner = corner + 3'd1;
    else if (state == esbb_pkg::S_DFIN) cmd.corner = 3'd0;
  end

endmodule

// ----- hw/rtl/esbb_dp.sv -----
// datapath: config rows, shared multiply-accumulate, bounds, z divider
`timescale 1ns / 1ps
module esbb_dp #(
  parameter int MAX_VERTICES = esbb_pkg::MAX_VERTICES_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_write,
  input  logic [esbb_pkg::CfgIdxW-1:0]         cfg_index,
  input  logic [esbb_pkg::RowW-1:0]            cfg_data,
  input  logic signed [esbb_pkg::CoordW-1:0]   vertex_x,
  input  logic signed [esbb_pkg::CoordW-1:0]   vertex_y,
  input  logic signed [esbb_pkg::CoordW-1:0]   vertex_z,
  input  logic                                 vertex_last,
  input  esbb_pkg::cmd_t                       cmd,
  output esbb_pkg::status_t                    status,
  output logic signed [esbb_pkg::CoordW-1:0]   quad_x,
  output logic signed [esbb_pkg::CoordW-1:0]   quad_y,
  output logic signed [esbb_pkg::CoordW-1:0]   quad_z,
  output logic                                 tex_u,
  output logic                                 tex_v,
  output logic                                 quad_last
);

  localparam int CntW = $clog2(MAX_VERTICES + 1);
  localparam int CW = esbb_pkg::CoordW;
  localparam int SW = esbb_pkg::SumW;
  localparam int AW = esbb_pkg::AccW;
  localparam int ShW = AW - esbb_pkg::FracDrop;

  logic [esbb_pkg::RowW-1:0] view0, view1, view2, inv0, inv1, inv2;
  logic signed [CW-1:0] vec_x, vec_y, vec_z;
  logic last_flag;
  logic signed [CW-1:0] res [3];
  logic signed [AW-1:0] acc;
  logic signed [CW-1:0] min_x, max_x, min_y, max_y, zq;
  logic [SW-1:0] z_sum;
  logic [CntW-1:0] cnt;
  logic [SW-1:0] quo;
  logic [CntW-1:0] rem;
  logic neg;
  logic [2:0] corner;
  logic [CntW:0] rem_sh;
  logic signed [SW:0] q_signed;
  logic signed [CW-1:0] zq_next;

  // config registers
  always_ff @(posedge clk) begin
    if (rst) begin
      view0 <= esbb_pkg::ROW0_RST;
      view1 <= esbb_pkg::ROW1_RST;
      view2 <= esbb_pkg::ROW2_RST;
      inv0 <= esbb_pkg::ROW0_RST;
      inv1 <= esbb_pkg::ROW1_RST;
      inv2 <= esbb_pkg::ROW2_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        esbb_pkg::REG_VIEW0: view0 <= cfg_data;
        esbb_pkg::REG_VIEW1: view1 <= cfg_data;
        esbb_pkg::REG_VIEW2: view2 <= cfg_data;
        esbb_pkg::REG_INV0:  inv0 <= cfg_data;
        esbb_pkg::REG_INV1:  inv1 <= cfg_data;
        esbb_pkg::REG_INV2:  inv2 <= cfg_data;
        default: ;
      endcase
    end
  end

  // multiply-accumulate, one matrix entry per cycle
  logic [esbb_pkg::RowW-1:0] mrow;
  logic signed [esbb_pkg::EntryW-1:0] entry;
  logic signed [CW-1:0] opnd;
  logic signed [esbb_pkg::EntryW+CW-1:0] prod;
  logic signed [AW-1:0] acc_sum;
  logic signed [ShW-1:0] shifted;
  logic signed [CW-1:0] sat_dot;

  always_comb begin
    case ({cmd.sel_inv, cmd.row})
      3'b000: mrow = view0;
      3'b001: mrow = view1;
      3'b010: mrow = view2;
      3'b100: mrow = inv0;
      3'b101: mrow = inv1;
      default: mrow = inv2;
    endcase
    entry = mrow[cmd.term*esbb_pkg::EntryW +: esbb_pkg::EntryW];
    case (cmd.term)
      2'd0: opnd = vec_x;
      2'd1: opnd = vec_y;
      2'd2: opnd = vec_z;
      default: opnd = CW'(32'sd65536);
    endcase
    prod = entry * opnd;
    acc_sum = acc + AW'(prod);
    // arithmetic shift floors, then clamp to 32 bits
    shifted = ShW'(acc_sum >>> esbb_pkg::FracDrop);
    if (shifted > ShW'(64'sh7fffffff)) sat_dot = {1'b0, {(CW-1){1'b1}}};
    else if (shifted < -ShW'(64'sh80000000)) sat_dot = {1'b1, {(CW-1){1'b0}}};
    else sat_dot = CW'(shifted);
  end

  always_ff @(posedge clk) begin
    if (cmd.mac) begin
      if (cmd.term == 2'd3) begin
        acc <= '0;
        res[cmd.row] <= sat_dot;
      end else begin
        acc <= acc_sum;
      end
    end else if (cmd.load_in) begin
      acc <= '0;
    end
  end

  // corner select feeds the inverse transform
  always_ff @(posedge clk) begin
    if (cmd.load_in) begin
      vec_x <= vertex_x;
      vec_y <= vertex_y;
      vec_z <= vertex_z;
      last_flag <= vertex_last;
    end else if (cmd.load_corner) begin
      vec_x <= esbb_pkg::corner_right(cmd.corner) ? max_x : min_x;
      vec_y <= esbb_pkg::corner_bottom(cmd.corner) ? min_y : max_y;
      vec_z <= cmd.div_fin ? zq_next : zq;
      corner <= cmd.corner;
    end
  end

  assign status.last = last_flag;

  // bounds, z sum, count
  always_ff @(posedge clk) begin
    if (rst || cmd.clear) begin
      min_x <= '0;
      max_x <= '0;
      min_y <= '0;
      max_y <= '0;
      z_sum <= '0;
      cnt <= '0;
    end else if (cmd.update) begin
      if (cnt == '0) begin
        min_x <= res[0];
        max_x <= res[0];
        min_y <= res[1];
        max_y <= res[1];
      end else begin
        if (res[0] > max_x) max_x <= res[0];
        else if (res[0] < min_x) min_x <= res[0];
        if (res[1] > max_y) max_y <= res[1];
        else if (res[1] < min_y) min_y <= res[1];
      end
      z_sum <= z_sum + SW'(res[2]);
      if (cnt < CntW'(MAX_VERTICES)) cnt <= cnt + CntW'(1);
    end
  end

  // restoring divider, one quotient bit per cycle on magnitudes
  always_comb begin
    rem_sh = {rem, quo[SW-1]};
    q_signed = neg ? -$signed({1'b0, quo}) : $signed({1'b0, quo});
    if (q_signed > (SW+1)'(64'sh7fffffff)) zq_next = {1'b0, {(CW-1){1'b1}}};
    else if (q_signed < -(SW+1)'(64'sh80000000)) zq_next = {1'b1, {(CW-1){1'b0}}};
    else zq_next = CW'(q_signed);
  end

  always_ff @(posedge clk) begin
    if (cmd.div_init) begin
      neg <= z_sum[SW-1];
      quo <= z_sum[SW-1] ? -z_sum : z_sum;
      rem <= '0;
    end else if (cmd.div_step) begin
      if (rem_sh >= {1'b0, cnt}) begin
        rem <= CntW'(rem_sh - {1'b0, cnt});
        quo <= {quo[SW-2:0], 1'b1};
      end else begin
        rem <= rem_sh[CntW-1:0];
        quo <= {quo[SW-2:0], 1'b0};
      end
    end
    if (cmd.div_fin) zq <= zq_next;
  end

  assign quad_x = res[0];
  assign quad_y = res[1];
  assign quad_z = res[2];
  assign tex_u = esbb_pkg::corner_right(corner);
  assign tex_v = esbb_pkg::corner_bottom(corner);
  assign quad_last = corner == 3'd5;

endmodule

// ----- hw/rtl/eye_space_bounding_billboard.sv -----
// top level of the eye-space bounding billboard
//  channel | signals                                   | direction
//  in      | in_valid, in_stall, vertex_x/y/z, _last   | vertex in
//  out     | out_valid, out_stall, quad_x/y/z, tex_u/v | quad vertex out
//  cfg     | cfg_write, cfg_index, cfg_data            | register write
// a vertex takes the accept state, 12 multiply-accumulate steps
// on one shared multiplier and one bounds update; the last vertex adds the z
// divide, then 12 inverse-transform steps per quad vertex plus any output stall
// synchronous reset restores identity matrices and clears the bounds
// input stalls while any work or output is pending
`timescale 1ns / 1ps
module eye_space_bounding_billboard #(
  parameter int MAX_VERTICES = esbb_pkg::MAX_VERTICES_DEF
) (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               cfg_write,
  input  logic [esbb_pkg::CfgIdxW-1:0]       cfg_index,
  input  logic [esbb_pkg::RowW-1:0]          cfg_data,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic signed [esbb_pkg::CoordW-1:0] vertex_x,
  input  logic signed [esbb_pkg::CoordW-1:0] vertex_y,
  input  logic signed [esbb_pkg::CoordW-1:0] vertex_z,
  input  logic                               vertex_last,
  output logic                               out_valid,
  input  logic                               out_stall,
  output logic signed [esbb_pkg::CoordW-1:0] quad_x,
  output logic signed [esbb_pkg::CoordW-1:0] quad_y,
  output logic signed [esbb_pkg::CoordW-1:0] quad_z,
  output logic                               tex_u,
  output logic                               tex_v,
  output logic                               quad_last
);

  esbb_pkg::cmd_t cmd;
  esbb_pkg::status_t status;

  esbb_ctrl u_ctrl (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .status(status), .cmd(cmd)
  );

  esbb_dp #(.MAX_VERTICES(MAX_VERTICES)) u_dp (
    .clk(clk), .rst(rst), .cfg_write(cfg_write), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .vertex_x(vertex_x), .vertex_y(vertex_y),
    .vertex_z(vertex_z), .vertex_last(vertex_last), .cmd(cmd), .status(status),
    .quad_x(quad_x), .quad_y(quad_y), .quad_z(quad_z), .tex_u(tex_u),
    .tex_v(tex_v), .quad_last(quad_last)
  );

endmodule
